>>> hw/rtl/tsmp_pkg.sv
// ----------------------------------------------------------------------------
// tsmp_pkg: shared types and constants of the 2D texture sampler
// register indexes, address mode codes and payload structs
// ----------------------------------------------------------------------------
`default_nettype none
package tsmp_pkg;
  localparam int MAX_TEXELS_DEF = 4096;
  localparam int MAX_DIM_DEF    = 64;

  // register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_AMODE  = 3'd2;
  localparam logic [2:0] REG_FILTER = 3'd3;
  localparam logic [2:0] REG_NORM   = 3'd4;
  localparam logic [2:0] REG_BORDER = 3'd5;

  // address modes
  localparam logic [1:0] AM_CLAMP  = 2'd0;
  localparam logic [1:0] AM_WRAP   = 2'd1;
  localparam logic [1:0] AM_MIRROR = 2'd2;
  localparam logic [1:0] AM_BORDER = 2'd3;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [11:0]        texel_index;
    logic signed [15:0] texel_value;
    logic signed [19:0] coord_u;
    logic signed [19:0] coord_v;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
  } out_item_t;
endpackage
`default_nettype wire

>>> hw/rtl/tsmp_in_if.sv
// ----------------------------------------------------------------------------
// tsmp_in_if: input channel of the texture sampler
// valid/ready handshake carrying one load or sample item
// ----------------------------------------------------------------------------
`default_nettype none
interface tsmp_in_if;
  logic               valid;
  logic               ready;
  tsmp_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tsmp_out_if.sv
// ----------------------------------------------------------------------------
// tsmp_out_if: result channel of the texture sampler
// valid/ready handshake carrying one sample value
// ----------------------------------------------------------------------------
`default_nettype none
interface tsmp_out_if;
  logic                valid;
  logic                ready;
  tsmp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/texture_sampler_2d.sv
// ----------------------------------------------------------------------------
// texture_sampler_2d: bilinear texture sampler with address modes
// texel store, coordinate resolver and one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
// A load transaction writes one texel in the cycle it is accepted, so loads can
// follow back to back. A sample transaction keeps the input stalled until its
// result has been handed over. Each texel coordinate is resolved in its own
// pass. For wrap and mirror the remainder by the size (twice the size for
// mirror) comes from a 12-step compare-and-subtract loop. Each texel is then
// addressed through the shared 28x10 multiplier, read from the store through a
// registered read and, in bilinear mode, weighted on the same multiplier.
// Normalized coordinates are first scaled on the multiplier in the NRMU and
// NRMV states, and a result that the output side does not take holds the
// sampler in its output state.
`default_nettype none
module texture_sampler_2d #(
  parameter int MAX_TEXELS = tsmp_pkg::MAX_TEXELS_DEF,
  parameter int MAX_DIM    = tsmp_pkg::MAX_DIM_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tsmp_in_if.sink   in_ch,
  tsmp_out_if.source out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import tsmp_pkg::*;

  localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;

  // state codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NRMU  = 4'd1;
  localparam logic [3:0] S_NRMV  = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_RES   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_FIX   = 4'd6;
  localparam logic [3:0] S_ADDR  = 4'd7;
  localparam logic [3:0] S_WAIT  = 4'd8;
  localparam logic [3:0] S_READ  = 4'd9;
  localparam logic [3:0] S_MULX  = 4'd10;
  localparam logic [3:0] S_MULY  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  // configuration registers
  logic [6:0]         width_r, height_r;
  logic [1:0]         amode_r;
  logic               filt_r, norm_r;
  logic signed [15:0] border_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 7'd1; height_r <= 7'd1; amode_r <= AM_CLAMP;
      filt_r <= 1'b0; norm_r <= 1'b0; border_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_WIDTH:  width_r  <= cfg_pwdata[6:0];
        REG_HEIGHT: height_r <= cfg_pwdata[6:0];
        REG_AMODE:  amode_r  <= cfg_pwdata[1:0];
        REG_FILTER: filt_r   <= cfg_pwdata[0];
        REG_NORM:   norm_r   <= cfg_pwdata[0];
        REG_BORDER: border_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_paddr[4:2])
      REG_WIDTH:  cfg_prdata = {25'd0, width_r};
      REG_HEIGHT: cfg_prdata = {25'd0, height_r};
      REG_AMODE:  cfg_prdata = {30'd0, amode_r};
      REG_FILTER: cfg_prdata = {31'd0, filt_r};
      REG_NORM:   cfg_prdata = {31'd0, norm_r};
      REG_BORDER: cfg_prdata = {16'd0, border_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // effective sizes
  logic [8:0] w_eff, h_eff;
  always_comb begin
    w_eff = (width_r == 7'd0) ? 9'd1 :
            ({2'd0, width_r} > 9'(MAX_DIM)) ? 9'(MAX_DIM) : {2'd0, width_r};
    h_eff = (height_r == 7'd0) ? 9'd1 :
            ({2'd0, height_r} > 9'(MAX_DIM)) ? 9'(MAX_DIM) : {2'd0, height_r};
  end

  // texel store
  logic [15:0]   mem [MAX_TEXELS];
  logic [AW-1:0] rd_addr_r;
  logic [15:0]   rd_data_r;
  logic [15:0]   ld_idx;

  // sequencer state
  logic [3:0]         st_r, st_nxt;
  logic signed [27:0] su_r, sv_r;
  logic signed [19:0] x0_r, y0_r;
  logic [7:0]         ax_r, ay_r;
  logic [1:0]         tap_r;       // which of the four texels
  logic               is_lin_r;
  logic signed [21:0] rc_r;        // coordinate under resolution
  logic               raxis_r;     // 0 x, 1 y
  logic [11:0]        num_r;       // magnitude shifted out by the remainder loop
  logic [7:0]         div_r;       // size or twice the size
  logic [7:0]         rem_r;
  logic [3:0]         cnt_r;
  logic [6:0]         cx_r, cy_r;  // resolved column and row
  logic               bx_r;        // column hits border
  logic               by_r;
  logic signed [16:0] tex_r;       // fetched value
  logic               oob_r;       // address beyond store
  logic signed [27:0] rowacc_r;
  logic signed [40:0] acc_r;
  logic signed [15:0] res_r;
  logic               out_v_r;

  // shared multiplier: 28-bit signed by 10-bit signed
  logic signed [27:0] mul_a;
  logic signed [9:0]  mul_b;
  logic signed [37:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [8:0] size_sel;
  assign size_sel = raxis_r ? h_eff : w_eff;

  always_comb begin
    mul_a = '0; mul_b = '0;
    case (st_r)
      S_NRMU: begin mul_a = su_r; mul_b = $signed({1'b0, w_eff}); end
      S_NRMV: begin mul_a = sv_r; mul_b = $signed({1'b0, h_eff}); end
      S_ADDR: begin mul_a = 28'(cy_r); mul_b = $signed({1'b0, w_eff}); end
      S_MULX: begin
        mul_a = 28'(tex_r);
        mul_b = tap_r[0] ? $signed({2'b0, ax_r}) : $signed(10'd256 - {2'b0, ax_r});
      end
      S_MULY: begin
        mul_a = rowacc_r;
        mul_b = tap_r[1] ? $signed({2'b0, ay_r}) : $signed(10'd256 - {2'b0, ay_r});
      end
      default: ;
    endcase
  end

  // tap coordinates
  logic signed [21:0] tx, ty;
  assign tx = 22'(x0_r) + 22'(tap_r[0]);
  assign ty = 22'(y0_r) + 22'(tap_r[1]);

  logic signed [21:0] sz;
  assign sz = 22'($signed({1'b0, size_sel}));

  // remainder loop operands: magnitude is below 4096 for every coordinate
  logic signed [21:0] res_c, res_mag;
  logic [7:0]         div_sel;
  logic [8:0]         trial;
  assign res_c   = raxis_r ? ty : tx;
  assign res_mag = (amode_r == AM_MIRROR) ? ((res_c < 0) ? ~res_c : res_c) :
                                            ((res_c < 0) ? -res_c : res_c);
  assign div_sel = (amode_r == AM_MIRROR) ? {size_sel[6:0], 1'b0} : {1'b0, size_sel[6:0]};
  assign trial   = {rem_r, num_r[11]};

  // final fold of the resolved coordinate
  logic [8:0] fix_c;
  logic       fix_brd;
  always_comb begin
    fix_c = '0;
    fix_brd = 1'b0;
    case (amode_r)
      AM_WRAP:
        fix_c = (rc_r < 0 && rem_r != 8'd0) ? size_sel - {1'b0, rem_r} : {1'b0, rem_r};
      AM_MIRROR:
        fix_c = ({1'b0, rem_r} >= size_sel) ? {1'b0, div_r} - 9'd1 - {1'b0, rem_r} :
                                              {1'b0, rem_r};
      AM_BORDER: begin
        fix_brd = (rc_r < 0) || (rc_r >= sz);
        fix_c = fix_brd ? 9'd0 : rc_r[8:0];
      end
      AM_CLAMP:
        fix_c = (rc_r < 0) ? 9'd0 : (rc_r >= sz) ? size_sel - 9'd1 : rc_r[8:0];
      default: ;
    endcase
  end

  // address compute
  logic [15:0] lin_addr;
  assign lin_addr = mul_p[15:0] + {9'd0, cx_r};

  logic fire_in, fire_out;
  assign in_ch.ready = (st_r == S_IDLE);
  assign fire_in  = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data.sample_value = res_r;
  assign fire_out = out_v_r && out_ch.ready;
  assign ld_idx = {4'd0, in_ch.data.texel_index};

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (fire_in && in_ch.data.kind == KIND_SAMPLE)
                st_nxt = norm_r ? S_NRMU : S_PREP;
      S_NRMU: st_nxt = S_NRMV;
      S_NRMV: st_nxt = S_PREP;
      S_PREP: st_nxt = S_RES;
      S_RES:  st_nxt = (amode_r == AM_WRAP || amode_r == AM_MIRROR) ? S_DIV : S_FIX;
      S_DIV:  if (cnt_r == 4'd11) st_nxt = S_FIX;
      S_FIX:  st_nxt = raxis_r ? S_ADDR : S_RES;
      S_ADDR: st_nxt = S_WAIT;
      S_WAIT: st_nxt = S_READ;
      S_READ: st_nxt = is_lin_r ? S_MULX : S_DONE;
      S_MULX: st_nxt = tap_r[0] ? S_MULY : S_RES;
      S_MULY: st_nxt = (tap_r == 2'd3) ? S_DONE : S_RES;
      S_DONE: st_nxt = S_OUT;
      S_OUT:  if (fire_out) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DONE) out_v_r <= 1'b1;
      else if (fire_out) out_v_r <= 1'b0;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (fire_in && in_ch.data.kind == KIND_LOAD &&
        {5'd0, in_ch.data.texel_index} < 17'(MAX_TEXELS))
      mem[ld_idx[AW-1:0]] <= in_ch.data.texel_value;
    rd_data_r <= mem[rd_addr_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        su_r <= 28'(in_ch.data.coord_u);
        sv_r <= 28'(in_ch.data.coord_v);
        is_lin_r <= filt_r;
        tap_r <= 2'd0;
        acc_r <= '0;
      end
      S_NRMU: su_r <= 28'(mul_p >>> 8);
      S_NRMV: sv_r <= 28'(mul_p >>> 8);
      S_PREP: begin
        if (is_lin_r) begin
          x0_r <= 20'((su_r - 28'sd128) >>> 8);
          y0_r <= 20'((sv_r - 28'sd128) >>> 8);
          ax_r <= 8'(su_r - 28'sd128);
          ay_r <= 8'(sv_r - 28'sd128);
        end else begin
          x0_r <= 20'(su_r >>> 8);
          y0_r <= 20'(sv_r >>> 8);
          ax_r <= '0; ay_r <= '0;
        end
        raxis_r <= 1'b0;
      end
      S_RES: begin
        // latch the coordinate and set up the remainder loop
        rc_r  <= res_c;
        num_r <= res_mag[11:0];
        div_r <= div_sel;
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        // one restoring step: shift in a bit, subtract the divisor if it fits
        rem_r <= (trial >= {1'b0, div_r}) ? 8'(trial - {1'b0, div_r}) : trial[7:0];
        num_r <= {num_r[10:0], 1'b0};
        cnt_r <= cnt_r + 4'd1;
      end
      S_FIX: begin
        if (!raxis_r) begin
          cx_r <= fix_c[6:0];
          bx_r <= fix_brd;
          raxis_r <= 1'b1;
        end else begin
          cy_r <= fix_c[6:0];
          by_r <= fix_brd;
        end
      end
      S_ADDR: begin
        oob_r <= ({1'b0, lin_addr} >= 17'(MAX_TEXELS));
        rd_addr_r <= lin_addr[AW-1:0];
      end
      S_READ: begin
        // border overrides, then out-of-store reads give zero
        if (bx_r || by_r) tex_r <= 17'(border_r);
        else if (oob_r)   tex_r <= '0;
        else              tex_r <= 17'($signed(rd_data_r));
        if (!is_lin_r) begin
          if (bx_r || by_r) res_r <= border_r;
          else if (oob_r)   res_r <= '0;
          else              res_r <= rd_data_r;
        end
      end
      S_MULX: begin
        rowacc_r <= tap_r[0] ? 28'(rowacc_r + 28'(mul_p)) : 28'(mul_p);
        if (!tap_r[0]) begin
          tap_r <= tap_r + 2'd1;
          raxis_r <= 1'b0;
        end
      end
      S_MULY: begin
        acc_r <= acc_r + 41'(mul_p);
        tap_r <= tap_r + 2'd1;
        raxis_r <= 1'b0;
      end
      S_DONE: if (is_lin_r) begin
        if ((acc_r >>> 16) > 41'sd32767)       res_r <= 16'sh7fff;
        else if ((acc_r >>> 16) < -41'sd32768) res_r <= 16'sh8000;
        else                                    res_r <= 16'(acc_r >>> 16);
      end
      default: ;
    endcase
  end

  // checks
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (st_r == S_OUT)) else $error("result outside output state");
  a_done_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |=> out_v_r) else $error("result lost");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> (out_v_r && $stable(res_r)))
    else $error("result changed while waiting");
endmodule
`default_nettype wire
